// ===== rtl/vhd_chs_geometry_unit_assert.svh =====
// Assertion macros for the VHD CHS geometry unit.
// No dependencies; included by the top level to check its own logic.
`ifndef VHD_CHS_GEOMETRY_UNIT_ASSERT_SVH
`define VHD_CHS_GEOMETRY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define VCG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// Next-cycle implication, disabled while reset is asserted.
`define VCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define VCG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VCG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/vcg_pkg.sv =====
// Constants for the VHD CHS geometry unit: sector limits, track codes and
// the reciprocal constants for division by 17, 31, 63, 255. No dependencies.
package vcg_pkg;

    // Sector count limits
    localparam logic [28:0] MAX_SECTORS = 29'd267382800;   // 65535*16*255
    localparam logic [28:0] BIG_SECTORS = 29'd66059280;    // 65535*16*63

    // Sectors per track codes
    localparam logic [7:0] SPT_17  = 8'd17;
    localparam logic [7:0] SPT_31  = 8'd31;
    localparam logic [7:0] SPT_63  = 8'd63;
    localparam logic [7:0] SPT_255 = 8'd255;

    // Head counts
    localparam logic [4:0] HEADS_MIN = 5'd4;
    localparam logic [4:0] HEADS_MAX = 5'd16;

    // Cylinder-times-heads limits (1024 cylinders per head)
    localparam logic [23:0] CTH_MIN_EXACT = 24'd4096;
    localparam logic [23:0] CTH_LIMIT     = 24'd16384;

    // Exact reciprocals ceil(2^k / d) for a 29-bit dividend
    localparam int unsigned SH17  = 34;
    localparam int unsigned SH31  = 34;
    localparam int unsigned SH63  = 35;
    localparam int unsigned SH255 = 37;
    localparam logic [29:0] M17  = 30'(((64'd1 << SH17)  + 64'd16)  / 64'd17);
    localparam logic [29:0] M31  = 30'(((64'd1 << SH31)  + 64'd30)  / 64'd31);
    localparam logic [29:0] M63  = 30'(((64'd1 << SH63)  + 64'd62)  / 64'd63);
    localparam logic [29:0] M255 = 30'(((64'd1 << SH255) + 64'd254) / 64'd255);

    // Shift for the divide-by-head reciprocal table
    localparam int unsigned SH_HEAD = 19;

    // ceil(2^19 / h) for h = 4..16; exact for dividends below 2^15
    function automatic logic [17:0] head_recip(input logic [4:0] h);
        logic [17:0] r;
        unique case (h)
            5'd4:    r = 18'd131072;
            5'd5:    r = 18'd104858;
            5'd6:    r = 18'd87382;
            5'd7:    r = 18'd74899;
            5'd8:    r = 18'd65536;
            5'd9:    r = 18'd58255;
            5'd10:   r = 18'd52429;
            5'd11:   r = 18'd47663;
            5'd12:   r = 18'd43691;
            5'd13:   r = 18'd40330;
            5'd14:   r = 18'd37450;
            5'd15:   r = 18'd34953;
            5'd16:   r = 18'd32768;
            default: r = 18'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/vhd_chs_geometry_unit.sv =====
// VHD CHS geometry unit: top level, depends on vcg_pkg and the assertion
// header. Turns a disk size in bytes into cylinders, heads and sectors per
// track. It takes one size per clock while o_stall is low. Each size passes
// through the register stages in order (clamp, reciprocal multiplies, track
// selection, divide by heads). A stall on the output holds the pipeline back
// stage by stage, filling bubbles first; o_stall follows i_stall in the same
// cycle once every stage holds a beat.
`include "vhd_chs_geometry_unit_assert.svh"

module vhd_chs_geometry_unit
    import vcg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [47:0] i_disk_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_cylinders,
    output logic [4:0]  o_heads,
    output logic [7:0]  o_track_sectors
);

    // Stage enables: a stage loads when empty or when the next one moves
    logic en1, en2, en3, en4;
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;

    assign en4     = !r_s4_valid || !i_stall;
    assign en3     = !r_s3_valid || en4;
    assign en2     = !r_s2_valid || en3;
    assign en1     = !r_s1_valid || en2;
    assign o_stall = !en1;
    assign o_valid = r_s4_valid;

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (en1) r_s1_valid <= i_valid;
            if (en2) r_s2_valid <= r_s1_valid;
            if (en3) r_s3_valid <= r_s2_valid;
            if (en4) r_s4_valid <= r_s3_valid;
        end
    end

    // Stage 1: whole sectors, clamped at the geometry limit
    logic [38:0] sec_full;
    logic [28:0] n_s1_sec;
    logic [28:0] r_s1_sec;
    logic        r_s1_big;

    assign sec_full = i_disk_bytes[47:9];
    assign n_s1_sec = (sec_full > 39'(MAX_SECTORS)) ? MAX_SECTORS : sec_full[28:0];

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_sec <= n_s1_sec;
            r_s1_big <= (n_s1_sec >= BIG_SECTORS);
        end
    end

    // Stage 2: divide by each track size through exact reciprocals
    logic [58:0] p17, p31, p63, p255;
    logic [23:0] r_s2_q17, r_s2_q31;
    logic [22:0] r_s2_q63;
    logic [20:0] r_s2_q255;
    logic        r_s2_big;

    assign p17  = 59'(r_s1_sec) * 59'(M17);
    assign p31  = 59'(r_s1_sec) * 59'(M31);
    assign p63  = 59'(r_s1_sec) * 59'(M63);
    assign p255 = 59'(r_s1_sec) * 59'(M255);

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_q17  <= p17[SH17 +: 24];
            r_s2_q31  <= p31[SH31 +: 24];
            r_s2_q63  <= p63[SH63 +: 23];
            r_s2_q255 <= p255[SH255 +: 21];
            r_s2_big  <= r_s1_big;
        end
    end

    // Stage 3: pick the track size and head count
    logic [14:0] h17_ceil;
    logic [4:0]  h17;
    logic        take31;
    logic        take63;
    logic [7:0]  n_s3_spt;
    logic [4:0]  n_s3_heads;
    logic [15:0] n_s3_cyl16;
    logic        n_s3_small;
    logic [7:0]  r_s3_spt;
    logic [4:0]  r_s3_heads;
    logic [15:0] r_s3_cyl16;
    logic        r_s3_small;
    logic [14:0] r_s3_q17;
    logic [17:0] r_s3_recip;

    assign h17_ceil = 15'(r_s2_q17[23:10]) + 15'(|r_s2_q17[9:0]);
    assign h17      = (h17_ceil < 15'(HEADS_MIN)) ? HEADS_MIN : h17_ceil[4:0];
    // 17 fails when the product needs more than 16 heads or fills its heads exactly
    assign take31   = (r_s2_q17 > CTH_LIMIT)
                   || ((r_s2_q17 >= CTH_MIN_EXACT) && (r_s2_q17[9:0] == 10'd0));
    assign take63   = (r_s2_q31 >= CTH_LIMIT);

    always_comb begin
        n_s3_small = 1'b0;
        n_s3_heads = HEADS_MAX;
        n_s3_spt   = SPT_255;
        n_s3_cyl16 = r_s2_q255[19:4];
        if (!r_s2_big) begin
            if (!take31) begin
                n_s3_small = 1'b1;
                n_s3_heads = h17;
                n_s3_spt   = SPT_17;
                n_s3_cyl16 = 16'd0;
            end else if (take63) begin
                n_s3_spt   = SPT_63;
                n_s3_cyl16 = r_s2_q63[19:4];
            end else begin
                n_s3_spt   = SPT_31;
                n_s3_cyl16 = r_s2_q31[19:4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_spt   <= n_s3_spt;
            r_s3_heads <= n_s3_heads;
            r_s3_cyl16 <= n_s3_cyl16;
            r_s3_small <= n_s3_small;
            r_s3_q17   <= r_s2_q17[14:0];
            r_s3_recip <= head_recip(n_s3_heads);
        end
    end

    // Stage 4: divide by a variable head count on the 17-sector path
    logic [32:0] p_head;
    logic [15:0] n_s4_cyl;

    assign p_head   = 33'(r_s3_q17) * 33'(r_s3_recip);
    assign n_s4_cyl = r_s3_small ? 16'(p_head[32:SH_HEAD]) : r_s3_cyl16;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            o_cylinders     <= n_s4_cyl;
            o_heads         <= r_s3_heads;
            o_track_sectors <= r_s3_spt;
        end
    end

    // Checks
    `VCG_ASSERT_IMPL(a_stall_needs_item, i_clk, i_rst_n, o_stall, r_s1_valid)
    `VCG_ASSERT_IMPL(a_wide_track_full_heads, i_clk, i_rst_n,
        o_valid && (o_track_sectors != SPT_17), o_heads == HEADS_MAX)
    `VCG_ASSERT_IMPL(a_track_code, i_clk, i_rst_n, o_valid,
        (o_track_sectors == SPT_17) || (o_track_sectors == SPT_31)
        || (o_track_sectors == SPT_63) || (o_track_sectors == SPT_255))
    `VCG_ASSERT_NEXT(a_held_under_stall, i_clk, i_rst_n, r_s4_valid && i_stall,
        r_s4_valid && $stable(o_cylinders) && $stable(o_heads))

endmodule
